### design/tlcc_pkg.sv
// Shared constants and types for the tripwire line-crossing counter.
// No dependencies; tlcc_div, the top level and the testbench import this package.
`timescale 1ns / 1ps

package tlcc_pkg;

  // Item kinds
  localparam logic [1:0] KIND_NEW   = 2'd0;
  localparam logic [1:0] KIND_TRACK = 2'd1;
  localparam logic [1:0] KIND_LOST  = 2'd2;

  // Count modes
  localparam logic [1:0] MODE_IN   = 2'd0;
  localparam logic [1:0] MODE_OUT  = 2'd1;
  localparam logic [1:0] MODE_BOTH = 2'd2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_EX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_EY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd5;

  // Fixed field widths
  localparam int ZONE_W  = 25;
  localparam int CNT_W   = 24;
  localparam int AREA_W  = 48;
  localparam int ADD_W   = 4;
  localparam int CROSS_W = 12;
  localparam int SPLIT_W = 16;

  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
  localparam logic [ADD_W-1:0]  SCALE_MAX = {ADD_W{1'b1}};

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic rem_nz;
  } div_stat_t;

endpackage

### design/tlcc_if.sv
// Valid/ready channel interfaces for blob items in and count items out.
// Depends on nothing; tlcc_in_if widths follow its parameters, tlcc_out_if is fixed.
`timescale 1ns / 1ps

interface tlcc_in_if #(
  parameter int SLOT_W     = 6,
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [SLOT_W-1:0]     track_slot;
  logic [COORD_BITS-1:0] box_x;
  logic [COORD_BITS-1:0] box_y;
  logic [COORD_BITS-1:0] box_w;
  logic [COORD_BITS-1:0] box_h;

  modport source (output valid, kind, track_slot, box_x, box_y, box_w, box_h, input ready);
  modport sink   (input valid, kind, track_slot, box_x, box_y, box_w, box_h, output ready);
endinterface

interface tlcc_out_if;
  logic        valid;
  logic        ready;
  logic        crossed;
  logic [3:0]  in_add;
  logic [3:0]  out_add;
  logic [11:0] cross_x;
  logic [11:0] cross_y;

  modport source (output valid, crossed, in_add, out_add, cross_x, cross_y, input ready);
  modport sink   (input valid, crossed, in_add, out_add, cross_x, cross_y, output ready);
endinterface

### design/tlcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tlcc_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### design/tlcc_mul.sv
// Shared signed multiplier with a registered product.
// No dependencies.
`timescale 1ns / 1ps

module tlcc_mul #(
  parameter int W = 25
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);
  // Register the product
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end
endmodule

### design/tlcc_div.sv
// Restoring divider, one quotient bit per cycle, divisor given pre-shifted.
// Depends on tlcc_pkg for the status struct.
`timescale 1ns / 1ps

module tlcc_div #(
  parameter int NW   = 53,
  parameter int QW   = 12,
  parameter int CNTW = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [NW-1:0]           num_i,
  input  logic [NW-1:0]           dsr_i,
  input  logic [CNTW-1:0]         steps_i,
  output tlcc_pkg::div_stat_t     stat_o,
  output logic [QW-1:0]           quot_o
);
  import tlcc_pkg::*;

  logic            busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   rem_q;
  logic [NW-1:0]   dsr_q;
  logic [QW-1:0]   quot_q;
  logic            ge;

  assign ge = rem_q >= dsr_q;

  // Control: load on start, count down the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: subtract where it fits, shift the divisor down
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      dsr_q  <= dsr_i;
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsr_q;
      end
      dsr_q  <= dsr_q >> 1;
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign stat_o.busy   = busy_q;
  assign stat_o.rem_nz = |rem_q;
  assign quot_o        = quot_q;
endmodule

### design/tripwire_line_crossing_counter.sv
// Top level: slot table, sequencer, shared multiplier and divider.
// Depends on tlcc_pkg, tlcc_if, tlcc_ram, tlcc_mul and tlcc_div.
//
//   port    | dir | handshake    | item
//   in_i    | in  | valid/ready  | kind, track_slot, box_x/y/w/h
//   out_o   | out | valid/ready  | crossed, in_add, out_add, cross_x/y
//   cfg_*   | in  | write enable | register index and data
//
// New, lost and ignored items go straight to the done state; a tracked item on
// a live slot first updates its phase. A sampled tracked item stops after the
// eight multiplier steps when the motion is parallel or the gate rejects it;
// when it crosses, a 4-step scale division (skipped when the scale saturates),
// then per axis a split multiply and a COORD_BITS-step division follow.
// in_i.ready is high only between items.
// Reset is asynchronous, active low; slot valid bits clear at once.
// A stalled out_o holds the result; the next item is taken meanwhile.
`timescale 1ns / 1ps

module tripwire_line_crossing_counter #(
  parameter int TRACK_SLOTS = 64,
  parameter int COORD_BITS  = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tlcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlcc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tlcc_in_if.sink                         in_i,
  tlcc_out_if.source                      out_o
);
  import tlcc_pkg::*;

  localparam int SLOT_W = $clog2(TRACK_SLOTS);
  localparam int CW     = COORD_BITS + 2;
  localparam int DW     = COORD_BITS + 1;
  localparam int VW     = COORD_BITS + 3;
  localparam int PW     = 2 * COORD_BITS + 6;
  localparam int AW     = 2 * COORD_BITS;
  localparam int MOP    = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam int PRW    = 2 * MOP;
  localparam int ACW    = COORD_BITS + PW;
  localparam int DV_A   = ((AW + CNT_W + 2) > (AREA_W + 5)) ? (AW + CNT_W + 2) : (AREA_W + 5);
  localparam int DIVW   = (DV_A > ACW) ? DV_A : ACW;
  localparam int QCW    = $clog2(COORD_BITS + 1);
  localparam int ENT_W  = 2 + 2 * CW;
  localparam int ZCW    = ((AW + 1) > ZONE_W) ? (AW + 1) : ZONE_W;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_CHK  = 12'b0000_0000_0010,
    ST_MUL  = 12'b0000_0000_0100,
    ST_TEST = 12'b0000_0000_1000,
    ST_GATE = 12'b0000_0001_0000,
    ST_SMUL = 12'b0000_0010_0000,
    ST_SNUM = 12'b0000_0100_0000,
    ST_SCMP = 12'b0000_1000_0000,
    ST_SDIV = 12'b0001_0000_0000,
    ST_XMUL = 12'b0010_0000_0000,
    ST_XDIV = 12'b0100_0000_0000,
    ST_DONE = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [COORD_BITS-1:0] lsx_q, lsy_q, lex_q, ley_q;
  logic [ZONE_W-1:0]     zone_q;
  logic [1:0]            mode_q;

  // Slot table and item registers
  logic [TRACK_SLOTS-1:0] vld_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [CW-1:0]          cx2_q, cy2_q;
  logic [COORD_BITS-1:0]  bw_q, bh_q;

  // Geometry and products
  logic signed [DW-1:0] ddx_q, ddy_q;
  logic signed [VW-1:0] d2x_q, d2y_q, rx_q, ry_q;
  logic signed [PW-1:0] det_q, tn_q, un_q;
  logic [AW-1:0]        area_q;
  logic [2:0]           mstep_q;
  logic [1:0]           xstep_q;
  logic                 axis_q;
  logic [ACW-1:0]       acc_q;
  logic [DIVW-1:0]      num_q;

  // Totals
  logic [CNT_W-1:0]  ct_q;
  logic [AREA_W-1:0] at_q;

  // Result registers
  logic                res_cross_q, inward_q;
  logic [ADD_W-1:0]    scale_q;
  logic [CROSS_W-1:0]  res_x_q, res_y_q;
  logic                out_valid_q;
  logic                out_cross_q;
  logic [ADD_W-1:0]    out_in_q, out_out_q;
  logic [CROSS_W-1:0]  out_x_q, out_y_q;

  // Handshake and slot decode
  logic              accept;
  logic              in_range;
  logic [CW-1:0]     in_cx2, in_cy2;
  logic              out_free;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign in_range   = {1'b0, in_i.track_slot} < (SLOT_W + 1)'(TRACK_SLOTS);
  assign in_cx2     = CW'({in_i.box_x, 1'b0}) + CW'(in_i.box_w);
  assign in_cy2     = CW'({in_i.box_y, 1'b0}) + CW'(in_i.box_h);
  assign out_free   = !out_valid_q || out_o.ready;

  // Slot memory: {phase, centre x2, centre y2}
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;
  logic [1:0]        ph_nxt;
  logic [CW-1:0]     old_cx2, old_cy2;

  assign ph_nxt  = ram_rdata[ENT_W-1 -: 2] + 2'd1;
  assign old_cx2 = ram_rdata[2*CW-1 -: CW];
  assign old_cy2 = ram_rdata[CW-1:0];

  always_comb begin
    if (state_q == ST_CHK) begin
      ram_we    = 1'b1;
      ram_waddr = slot_q;
      ram_wdata = (ph_nxt != 2'd0) ? {ph_nxt, old_cx2, old_cy2} : {ph_nxt, cx2_q, cy2_q};
    end else begin
      ram_we    = accept && in_range && (in_i.kind == KIND_NEW);
      ram_waddr = in_i.track_slot;
      ram_wdata = {2'd1, in_cx2, in_cy2};
    end
  end

  tlcc_ram #(.WIDTH(ENT_W), .DEPTH(TRACK_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (in_i.track_slot),
    .rdata_o (ram_rdata)
  );

  // Shared multiplier operand select
  logic signed [MOP-1:0] mul_a, mul_b;
  logic signed [PRW-1:0] mul_p;
  logic signed [VW-1:0]  d1x, d1y;
  logic [DW-1:0]         dd_mag;
  logic [ACW-1:0]        p_acw;

  assign d1x    = VW'($signed({ddx_q, 1'b0}));
  assign d1y    = VW'($signed({ddy_q, 1'b0}));
  assign dd_mag = axis_q ? (ddy_q[DW-1] ? DW'(-ddy_q) : DW'(ddy_q))
                         : (ddx_q[DW-1] ? DW'(-ddx_q) : DW'(ddx_q));
  assign p_acw  = ACW'(mul_p);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MUL: begin
        unique case (mstep_q)
          3'd0: begin mul_a = MOP'(d1x);  mul_b = MOP'(d2y_q); end
          3'd1: begin mul_a = MOP'(d1y);  mul_b = MOP'(d2x_q); end
          3'd2: begin mul_a = MOP'(rx_q); mul_b = MOP'(d2y_q); end
          3'd3: begin mul_a = MOP'(ry_q); mul_b = MOP'(d2x_q); end
          3'd4: begin mul_a = MOP'(rx_q); mul_b = MOP'(d1y);   end
          3'd5: begin mul_a = MOP'(ry_q); mul_b = MOP'(d1x);   end
          3'd6: begin
            mul_a = $signed(MOP'(bw_q));
            mul_b = $signed(MOP'(bh_q));
          end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_SMUL: begin
        mul_a = $signed(MOP'(area_q));
        mul_b = $signed(MOP'(ct_q));
      end
      ST_XMUL: begin
        mul_a = $signed(MOP'(dd_mag));
        mul_b = (xstep_q == 2'd0) ? $signed(MOP'(tn_q[PW-1:SPLIT_W]))
                                  : $signed(MOP'(tn_q[SPLIT_W-1:0]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tlcc_mul #(.W(MOP)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Shared divider start and operands
  logic             div_start;
  logic [DIVW-1:0]  div_num, div_dsr;
  logic [QCW-1:0]   div_steps;
  div_stat_t        div_stat;
  logic [COORD_BITS-1:0] div_quot;
  logic             scale_sat;

  assign scale_sat = num_q >= (DIVW'(at_q) << 5);

  always_comb begin
    div_start = 1'b0;
    div_num   = num_q;
    div_dsr   = DIVW'(at_q) << 4;
    div_steps = QCW'(ADD_W);
    if (state_q == ST_SCMP) begin
      div_start = !scale_sat;
    end else if (state_q == ST_XMUL && xstep_q == 2'd2) begin
      div_start = 1'b1;
      div_num   = DIVW'(acc_q + p_acw);
      div_dsr   = DIVW'($unsigned(det_q)) << (COORD_BITS - 1);
      div_steps = QCW'(COORD_BITS);
    end
  end

  tlcc_div #(.NW(DIVW), .QW(COORD_BITS), .CNTW(QCW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .dsr_i   (div_dsr),
    .steps_i (div_steps),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  // Crossing coordinate from the quotient, floored toward minus infinity
  logic [DW-1:0]         coord_full;
  logic [DW-1:0]         coord_mag;
  logic                  dd_neg;
  logic [COORD_BITS-1:0] coord_start;

  assign dd_neg      = axis_q ? ddy_q[DW-1] : ddx_q[DW-1];
  assign coord_start = axis_q ? lsy_q : lsx_q;
  assign coord_mag   = DW'(div_quot) + DW'(div_stat.rem_nz);
  assign coord_full  = dd_neg ? (DW'(coord_start) - coord_mag)
                              : (DW'(coord_start) + DW'(div_quot));

  // Gate checks on the normalized products, the area and the zone threshold
  logic gate_fail;
  assign gate_fail = tn_q[PW-1] || (tn_q > det_q) || un_q[PW-1] || (un_q > det_q)
                  || (area_q == '0) || (ZCW'({area_q, 1'b0}) < ZCW'(zone_q));

  logic [AREA_W:0] at_sum;
  assign at_sum = (AREA_W + 1)'(at_q) + (AREA_W + 1)'(area_q);

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_range && in_i.kind == KIND_TRACK && vld_q[in_i.track_slot]) begin
            state_d = ST_CHK;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_CHK:  state_d = (ph_nxt == 2'd0) ? ST_MUL : ST_DONE;
      ST_MUL:  state_d = (mstep_q == 3'd7) ? ST_TEST : ST_MUL;
      ST_TEST: state_d = (det_q == '0) ? ST_DONE : ST_GATE;
      ST_GATE: state_d = gate_fail ? ST_DONE : ST_SMUL;
      ST_SMUL: state_d = ST_SNUM;
      ST_SNUM: state_d = ST_SCMP;
      ST_SCMP: state_d = scale_sat ? ST_XMUL : ST_SDIV;
      ST_SDIV: state_d = div_stat.busy ? ST_SDIV : ST_XMUL;
      ST_XMUL: state_d = (xstep_q == 2'd2) ? ST_XDIV : ST_XMUL;
      ST_XDIV: begin
        if (!div_stat.busy) begin
          state_d = axis_q ? ST_DONE : ST_XMUL;
        end
      end
      ST_DONE: state_d = out_free ? ST_IDLE : ST_DONE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vld_q       <= '0;
      ct_q        <= '0;
      at_q        <= '0;
      mstep_q     <= '0;
      xstep_q     <= '0;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
      lsx_q       <= '0;
      lsy_q       <= '0;
      lex_q       <= '0;
      ley_q       <= '0;
      zone_q      <= '0;
      mode_q      <= MODE_BOTH;
    end else begin
      state_q <= state_d;

      // Take configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LINE_SX: lsx_q  <= cfg_data_i[COORD_BITS-1:0];
          CFG_LINE_SY: lsy_q  <= cfg_data_i[COORD_BITS-1:0];
          CFG_LINE_EX: lex_q  <= cfg_data_i[COORD_BITS-1:0];
          CFG_LINE_EY: ley_q  <= cfg_data_i[COORD_BITS-1:0];
          CFG_ZONE:    zone_q <= cfg_data_i[ZONE_W-1:0];
          CFG_MODE:    mode_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end

      // Fill and free slots
      if (accept && in_range) begin
        if (in_i.kind == KIND_NEW) begin
          vld_q[in_i.track_slot] <= 1'b1;
        end else if (in_i.kind == KIND_LOST) begin
          vld_q[in_i.track_slot] <= 1'b0;
        end
      end

      // Step counters
      if (state_q == ST_MUL) begin
        mstep_q <= mstep_q + 3'd1;
      end else begin
        mstep_q <= '0;
      end
      if (state_q == ST_XMUL) begin
        xstep_q <= (xstep_q == 2'd2) ? 2'd0 : xstep_q + 2'd1;
      end
      if (state_q == ST_IDLE) begin
        axis_q <= 1'b0;
      end else if (state_q == ST_XDIV && !div_stat.busy) begin
        axis_q <= 1'b1;
      end

      // Advance the totals on a counted crossing
      if (state_q == ST_GATE && !gate_fail && ct_q != CNT_MAX) begin
        ct_q <= ct_q + CNT_W'(1);
        at_q <= at_sum[AREA_W] ? AREA_MAX : at_sum[AREA_W-1:0];
      end

      // Output register: load a finished item, drop it once taken
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q      <= in_i.track_slot;
      cx2_q       <= in_cx2;
      cy2_q       <= in_cy2;
      bw_q        <= in_i.box_w;
      bh_q        <= in_i.box_h;
      res_cross_q <= 1'b0;
      res_x_q     <= '0;
      res_y_q     <= '0;
      scale_q     <= '0;
    end

    // Motion and line vectors from the stored centre
    if (state_q == ST_CHK) begin
      ddx_q <= DW'(lex_q) - DW'(lsx_q);
      ddy_q <= DW'(ley_q) - DW'(lsy_q);
      d2x_q <= VW'(cx2_q) - VW'(old_cx2);
      d2y_q <= VW'(cy2_q) - VW'(old_cy2);
      rx_q  <= VW'(old_cx2) - VW'({lsx_q, 1'b0});
      ry_q  <= VW'(old_cy2) - VW'({lsy_q, 1'b0});
    end

    // Accumulate cross products from the registered multiplier product
    if (state_q == ST_MUL) begin
      unique case (mstep_q)
        3'd1: det_q  <= PW'(mul_p);
        3'd2: det_q  <= det_q - PW'(mul_p);
        3'd3: tn_q   <= PW'(mul_p);
        3'd4: tn_q   <= tn_q - PW'(mul_p);
        3'd5: un_q   <= PW'(mul_p);
        3'd6: un_q   <= un_q - PW'(mul_p);
        3'd7: area_q <= AW'(mul_p);
        default: ;
      endcase
    end

    // Normalize to a positive determinant
    if (state_q == ST_TEST) begin
      inward_q <= det_q[PW-1];
      if (det_q[PW-1]) begin
        det_q <= -det_q;
        tn_q  <= -tn_q;
        un_q  <= -un_q;
      end
    end

    if (state_q == ST_GATE && !gate_fail) begin
      res_cross_q <= 1'b1;
    end

    // Scale numerator and result
    if (state_q == ST_SNUM) begin
      num_q <= (DIVW'($unsigned(mul_p)) << 1) + DIVW'(at_q);
    end
    if (state_q == ST_SCMP && scale_sat) begin
      scale_q <= SCALE_MAX;
    end
    if (state_q == ST_SDIV && !div_stat.busy) begin
      scale_q <= div_quot[ADD_W-1:0];
    end

    // Split product for the crossing coordinate
    if (state_q == ST_XMUL && xstep_q == 2'd1) begin
      acc_q <= p_acw << SPLIT_W;
    end
    if (state_q == ST_XDIV && !div_stat.busy) begin
      if (axis_q) begin
        res_y_q <= CROSS_W'(coord_full[COORD_BITS-1:0]);
      end else begin
        res_x_q <= CROSS_W'(coord_full[COORD_BITS-1:0]);
      end
    end

    // Load the output item
    if (state_q == ST_DONE && out_free) begin
      out_cross_q <= res_cross_q;
      out_in_q    <= (res_cross_q && inward_q && (mode_q == MODE_IN || mode_q == MODE_BOTH))
                     ? scale_q : '0;
      out_out_q   <= (res_cross_q && !inward_q && (mode_q == MODE_OUT || mode_q == MODE_BOTH))
                     ? scale_q : '0;
      out_x_q     <= res_x_q;
      out_y_q     <= res_y_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.crossed = out_cross_q;
  assign out_o.in_add  = out_in_q;
  assign out_o.out_add = out_out_q;
  assign out_o.cross_x = out_x_q;
  assign out_o.cross_y = out_y_q;

  // Checks
  a_no_meaning_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.crossed) |->
      (out_o.in_add == '0 && out_o.out_add == '0 && out_o.cross_x == '0 && out_o.cross_y == '0))
    else $error("fields set on an item without a crossing");

  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.in_add == '0 || out_o.out_add == '0))
    else $error("both direction counts set");

  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (ct_q >= $past(ct_q)))
    else $error("crossing total went down");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_stat.busy)
    else $error("divider busy between items");
endmodule

### sim/tripwire_line_crossing_counter_tb.sv
// Self-checking testbench for the tripwire line-crossing counter.
// Depends on tlcc_pkg, tlcc_if and the tripwire_line_crossing_counter RTL.
// Runs blob tracks through the block and checks each count item against a local predictor.
`timescale 1ns / 1ps

module tripwire_line_crossing_counter_tb;
  import tlcc_pkg::*;

  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] w;
    logic [11:0] h;
  } blob_t;

  typedef struct packed {
    logic        crossed;
    logic [3:0]  in_add;
    logic [3:0]  out_add;
    logic [11:0] cx;
    logic [11:0] cy;
  } count_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  tlcc_in_if #(.SLOT_W(6), .COORD_BITS(12)) in_ch ();
  tlcc_out_if out_ch ();

  tripwire_line_crossing_counter dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  // Predictor state
  bit          slot_live [SLOTS];
  bit [1:0]    slot_ph [SLOTS];
  bit [13:0]   ctr_x2 [SLOTS];
  bit [13:0]   ctr_y2 [SLOTS];
  bit [23:0]   n_cross;
  bit [47:0]   area_sum;
  bit [11:0]   ln_sx, ln_sy, ln_ex, ln_ey;
  bit [24:0]   zone;
  bit [1:0]    mode;

  count_t expected_counts[$];
  int errors = 0;
  int items_sent = 0;
  int cycles = 0;
  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  bit hold_req = 1'b0;

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [11:0] cross_at(longint a2, longint d, longint tn, longint det);
    longint num;
    num = a2 * det + d * tn;
    if (num < 0) num = 0;
    return 12'(num / (2 * det));
  endfunction

  // Advance the predictor by one blob item and return its count item
  function automatic count_t predict_count(blob_t b);
    count_t r;
    longint cx2, cy2, area, px, py, ax2, ay2, d1x, d1y, d2x, d2y, rx, ry, det, tn, un, scale;
    bit inward;
    r = '0;
    cx2 = 2 * longint'(b.x) + longint'(b.w);
    cy2 = 2 * longint'(b.y) + longint'(b.h);
    area = longint'(b.w) * longint'(b.h);
    if (b.kind == KIND_NEW) begin
      slot_live[b.slot] = 1'b1;
      slot_ph[b.slot] = 2'd1;
      ctr_x2[b.slot] = 14'(cx2);
      ctr_y2[b.slot] = 14'(cy2);
      return r;
    end
    if (b.kind == KIND_LOST) begin
      slot_live[b.slot] = 1'b0;
      return r;
    end
    if (b.kind != KIND_TRACK || !slot_live[b.slot]) return r;
    slot_ph[b.slot] = slot_ph[b.slot] + 2'd1;
    if (slot_ph[b.slot] != 2'd0) return r;
    px = ctr_x2[b.slot];
    py = ctr_y2[b.slot];
    ctr_x2[b.slot] = 14'(cx2);
    ctr_y2[b.slot] = 14'(cy2);
    ax2 = 2 * longint'(ln_sx);
    ay2 = 2 * longint'(ln_sy);
    d1x = 2 * (longint'(ln_ex) - longint'(ln_sx));
    d1y = 2 * (longint'(ln_ey) - longint'(ln_sy));
    d2x = cx2 - px;
    d2y = cy2 - py;
    rx = px - ax2;
    ry = py - ay2;
    det = d1x * d2y - d1y * d2x;
    if (det == 0) return r;
    tn = rx * d2y - ry * d2x;
    un = rx * d1y - ry * d1x;
    inward = det < 0;
    if (inward) begin
      det = -det;
      tn = -tn;
      un = -un;
    end
    if (tn < 0 || tn > det || un < 0 || un > det) return r;
    if (area == 0 || 2 * area < longint'(zone)) return r;
    if (n_cross != CNT_MAX) begin
      n_cross++;
      if (longint'(area_sum) + area > longint'(AREA_MAX)) area_sum = AREA_MAX;
      else area_sum = 48'(longint'(area_sum) + area);
    end
    scale = (2 * area * longint'(n_cross) + longint'(area_sum)) / (2 * longint'(area_sum));
    if (scale > 15) scale = 15;
    r.crossed = 1'b1;
    if (inward) begin
      if (mode == MODE_IN || mode == MODE_BOTH) r.in_add = 4'(scale);
    end else begin
      if (mode == MODE_OUT || mode == MODE_BOTH) r.out_add = 4'(scale);
    end
    r.cx = cross_at(ax2, d1x, tn, det);
    r.cy = cross_at(ay2, d1y, tn, det);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Compare each accepted count item with the oldest expectation
  always @(posedge clk_i) begin
    count_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_counts.size() == 0) begin
        report_mismatch("unexpected count item", 1, 0);
      end else begin
        want = expected_counts.pop_front();
        if (out_ch.crossed !== want.crossed) report_mismatch("crossed", out_ch.crossed, want.crossed);
        if (out_ch.in_add !== want.in_add) report_mismatch("in_add", out_ch.in_add, want.in_add);
        if (out_ch.out_add !== want.out_add) report_mismatch("out_add", out_ch.out_add, want.out_add);
        if (out_ch.cross_x !== want.cx) report_mismatch("cross_x", out_ch.cross_x, want.cx);
        if (out_ch.cross_y !== want.cy) report_mismatch("cross_y", out_ch.cross_y, want.cy);
      end
    end
  end

  // Drive the output ready: random stalls, plus one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(sink_idle_on && $urandom_range(0, 99) < 19);
      end
    end
  end

  // Offer one item from a falling edge; return at the falling edge after acceptance
  task automatic send_blob(blob_t b);
    if (src_idle_on && $urandom_range(0, 99) < 19) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= b.kind;
    in_ch.track_slot <= b.slot;
    in_ch.box_x <= b.x;
    in_ch.box_y <= b.y;
    in_ch.box_w <= b.w;
    in_ch.box_h <= b.h;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_counts = {expected_counts, predict_count(b)};
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every count item is back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_DATA_W'(data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LINE_SX: ln_sx = 12'(data);
      CFG_LINE_SY: ln_sy = 12'(data);
      CFG_LINE_EX: ln_ex = 12'(data);
      CFG_LINE_EY: ln_ey = 12'(data);
      CFG_ZONE:    zone = 25'(data);
      CFG_MODE:    mode = 2'(data);
      default: ;
    endcase
  endtask

  task automatic set_config(int sx, int sy, int ex, int ey, int unsigned z, int m);
    wait_idle();
    write_reg(CFG_LINE_SX, sx);
    write_reg(CFG_LINE_SY, sy);
    write_reg(CFG_LINE_EX, ex);
    write_reg(CFG_LINE_EY, ey);
    write_reg(CFG_ZONE, z);
    write_reg(CFG_MODE, m);
  endtask

  function automatic blob_t make_blob(logic [1:0] k, int s, int cx, int cy, int w, int h);
    blob_t b;
    int x, y;
    x = cx - w / 2;
    y = cy - h / 2;
    b.kind = k;
    b.slot = 6'(s);
    b.x = 12'((x < 0) ? 0 : (x > 4095) ? 4095 : x);
    b.y = 12'((y < 0) ? 0 : (y > 4095) ? 4095 : y);
    b.w = 12'(w);
    b.h = 12'(h);
    return b;
  endfunction

  // New track, two unsampled updates, then the sampled update that tests the line
  task automatic run_track(int s, int ox, int oy, int nx, int ny, int w, int h);
    send_blob(make_blob(KIND_NEW, s, ox, oy, w, h));
    send_blob(make_blob(KIND_TRACK, s, ox + 3, oy, w, h));
    send_blob(make_blob(KIND_TRACK, s, ox, oy + 3, w, h));
    send_blob(make_blob(KIND_TRACK, s, nx, ny, w, h));
  endtask

  task automatic test_directed();
    set_config(1000, 0, 1000, 4095, 0, MODE_BOTH);
    // Cross inward and then outward on one slot
    run_track(0, 900, 500, 1100, 520, 20, 20);
    send_blob(make_blob(KIND_TRACK, 0, 1100, 520, 20, 20));
    send_blob(make_blob(KIND_TRACK, 0, 1000, 500, 20, 20));
    send_blob(make_blob(KIND_TRACK, 0, 1050, 500, 20, 20));
    send_blob(make_blob(KIND_TRACK, 0, 900, 700, 40, 30));
    // Lost, then updates on the freed slot are ignored
    send_blob(make_blob(KIND_LOST, 0, 0, 0, 0, 0));
    send_blob(make_blob(KIND_TRACK, 0, 0, 0, 0, 0));
    // Unknown kind and extreme fields
    send_blob('{kind: 2'd3, slot: 6'd63, x: 12'hfff, y: 12'hfff, w: 12'hfff, h: 12'hfff});
    send_blob('{kind: KIND_NEW, slot: 6'd63, x: 12'hfff, y: 12'hfff, w: 12'hfff, h: 12'hfff});
    // New on a live slot restarts the phase; zero area and parallel motion
    send_blob(make_blob(KIND_NEW, 63, 900, 100, 0, 10));
    run_track(63, 900, 100, 1100, 100, 0, 10);
    run_track(5, 1000, 100, 1000, 900, 10, 10);
    // Motion ending exactly on the line counts
    run_track(6, 800, 300, 1000, 300, 2, 2);
  endtask

  task automatic test_zone_and_modes();
    int m;
    set_config(4095, 0, 0, 4095, 16777216, MODE_BOTH);
    run_track(1, 1800, 1800, 2300, 2300, 4095, 4095);
    run_track(2, 1800, 1800, 2300, 2300, 100, 100);
    for (m = 0; m < 4; m++) begin
      set_config(0, 2000, 4095, 2000, 50, m);
      run_track(3, 500, 1900, 600, 2100, 10, 10);
      run_track(4, 700, 2100, 800, 1900, 10, 10);
    end
  endtask

  task automatic random_track();
    int s, t, mx, my, ox, oy, w, h, k;
    s = $urandom_range(0, SLOTS - 1);
    t = $urandom_range(0, 1000);
    mx = int'(ln_sx) + (int'(ln_ex) - int'(ln_sx)) * t / 1000;
    my = int'(ln_sy) + (int'(ln_ey) - int'(ln_sy)) * t / 1000;
    ox = $urandom_range(0, 600) - 300;
    oy = $urandom_range(0, 600) - 300;
    case ($urandom_range(0, 9))
      0: begin w = $urandom_range(0, 4095); h = $urandom_range(0, 4095); end
      1: begin w = 0; h = $urandom_range(0, 50); end
      default: begin w = $urandom_range(1, 200); h = $urandom_range(1, 200); end
    endcase
    run_track(s, mx - ox, my - oy, mx + ox, my + oy, w, h);
    // Sometimes keep going back across, then lose the track
    if ($urandom_range(0, 2) == 0) begin
      for (k = 0; k < 3; k++) send_blob(make_blob(KIND_TRACK, s, mx, my, w, h));
      send_blob(make_blob(KIND_TRACK, s, mx - ox, my - oy, w, h));
    end
    if ($urandom_range(0, 3) == 0) send_blob(make_blob(KIND_LOST, s, mx, my, w, h));
  endtask

  task automatic random_noise();
    blob_t b;
    b.kind = 2'($urandom_range(0, 3));
    b.slot = 6'($urandom);
    b.x = 12'($urandom);
    b.y = 12'($urandom);
    b.w = 12'($urandom);
    b.h = 12'($urandom);
    send_blob(b);
  endtask

  task automatic test_random(int target);
    int ph;
    int unsigned z;
    ph = 0;
    while (items_sent < target) begin
      case ($urandom_range(0, 3))
        0: z = 0;
        1: z = 16777216;
        default: z = $urandom_range(0, 20000);
      endcase
      set_config($urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 4095), z, ph % 4);
      // One phase runs without any idling on either side
      src_idle_on = (ph != 2);
      sink_idle_on = (ph != 2);
      repeat (30) begin
        if (items_sent < target) begin
          if ($urandom_range(0, 4) == 0) random_noise();
          else random_track();
        end
      end
      ph++;
    end
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Stall the output for a long stretch while items keep coming
  task automatic test_backpressure();
    set_config(2000, 0, 2000, 4095, 0, MODE_BOTH);
    hold_req = 1'b1;
    repeat (6) random_track();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.track_slot = '0;
    in_ch.box_x = '0;
    in_ch.box_y = '0;
    in_ch.box_w = '0;
    in_ch.box_h = '0;
    ln_sx = '0; ln_sy = '0; ln_ex = '0; ln_ey = '0;
    zone = '0;
    mode = MODE_BOTH;
    n_cross = '0;
    area_sum = '0;
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_zone_and_modes();
    test_backpressure();
    test_random(850);

    wait_idle();
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### tripwire_line_crossing_counter.f
design/tlcc_pkg.sv
design/tlcc_if.sv
design/tlcc_ram.sv
design/tlcc_mul.sv
design/tlcc_div.sv
design/tripwire_line_crossing_counter.sv
sim/tripwire_line_crossing_counter_tb.sv
